/* rtl/core/tli_pkg.sv */
// package for the table linear interpolator: sizes, codes and state type
// no dependencies
`timescale 1ns / 1ps

package tli_pkg;

    localparam int MaxPoints = 1024;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = IdxW + 1;
    localparam int ValW      = 32;
    localparam int MagW      = 33;
    localparam int ProdW     = 2 * MagW;
    localparam int QW        = ProdW;

    localparam logic [1:0] StatusOk   = 2'd0;
    localparam logic [1:0] StatusFlat = 2'd1;
    localparam logic [1:0] StatusSat  = 2'd2;

    localparam logic ActLoad  = 1'b0;
    localparam logic ActQuery = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_ENDS,
        ST_CHK_LAST,
        ST_CHK_FIRST,
        ST_SEARCH,
        ST_SEARCH_WAIT,
        ST_RD_SEG0,
        ST_RD_SEG1,
        ST_SEG_WAIT,
        ST_MULT,
        ST_DIV_GO,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } tli_state_t;

    // divider control between top and divider
    typedef struct packed {
        logic start;
    } tli_div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tli_div_sts_t;

endpackage

/* rtl/core/tli_divider.sv */
// restoring divider, one quotient bit per cycle
// depends on tli_pkg
`timescale 1ns / 1ps

module tli_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tli_pkg::tli_div_ctl_t         ctl,
    input  logic [tli_pkg::ProdW-1:0]     dividend,
    input  logic [tli_pkg::MagW-1:0]      divisor,
    output tli_pkg::tli_div_sts_t         sts,
    output logic [tli_pkg::QW-1:0]        quotient
);
    import tli_pkg::*;

    localparam int StepW = $clog2(ProdW + 1);

    logic [ProdW-1:0] num_reg, num_next;
    logic [MagW:0]    rem_reg, rem_next;
    logic [MagW-1:0]  den_reg, den_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [MagW:0]    trial;

    // load the operands on start, else one shift-subtract step
    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[MagW-1:0], num_reg[ProdW-1]};
        if (ctl.start) begin
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            step_next = StepW'(ProdW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[ProdW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next    = trial - {1'b0, den_reg};
                num_next[0] = 1'b1;
            end else begin
                rem_next = trial;
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        step_reg <= step_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = num_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |=> busy_reg) else $error("start did not set busy");
`endif

endmodule

/* rtl/core/table_linear_interpolator.sv */
// Piecewise linear interpolation table, signed Q16.16. Load items (tuser=0)
// write breakpoint x and value y at an index and give no result; a load
// leaves the block ready, so loads can follow back to back. Query items
// (tuser=1) give one result. A query compares the key with the last
// breakpoint, then the first, and otherwise runs a binary search (at most
// log2(n) + 1 steps, each one memory read and one compare). A bit-serial
// divider then runs behind a 33x33 multiply; a zero-width segment skips
// the divide. The result waits until taken, and the next item is accepted
// in the cycle after that. The tables need no clearing after reset.
// depends on tli_pkg and tli_divider
`timescale 1ns / 1ps

module table_linear_interpolator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index[9:0], entry_x[41:10], entry_y[73:42], query_key[105:74], zero pad
    input  logic [111:0] s_tdata,
    // action
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_value[31:0], status[33:32], zero pad
    output logic [39:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [10:0]  cfg_data
);
    import tli_pkg::*;

    // tables
    logic [ValW-1:0] xmem [MaxPoints];
    logic [ValW-1:0] ymem [MaxPoints];
    logic [ValW-1:0] xrd_reg, yrd_reg;
    logic            we;
    logic [IdxW-1:0] raddr;

    tli_state_t state_reg, state_next;

    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] n_used;
    logic signed [ValW-1:0] key_reg;
    logic [CntW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [IdxW-1:0] n0_reg, n0_next;
    logic signed [ValW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [ValW-1:0] x0_next, y0_next, x1_next, y1_next;
    logic [ProdW-1:0] prod_reg;
    logic [MagW-1:0]  dxm_reg;
    logic             neg_reg, flat_reg;
    logic [ValW-1:0]  res_reg, res_next;
    logic [1:0]       stat_reg, stat_next;
    logic             in_acc;

    tli_div_ctl_t dctl;
    tli_div_sts_t dsts;
    logic [QW-1:0] quot;

    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {6'd0, stat_reg, res_reg};
    assign we        = in_acc && (s_tuser[0] == ActLoad);

    // clamp the entry count
    always_comb begin
        if (count_reg < CntW'(2))              n_used = CntW'(2);
        else if (count_reg > CntW'(MaxPoints)) n_used = CntW'(MaxPoints);
        else                                   n_used = count_reg;
    end

    assign mid = CntW'((lo_reg + hi_reg) >> 1);

    // read address per state
    always_comb begin
        case (state_reg)
            ST_IDLE:     raddr = IdxW'(n_used - 1'b1);
            ST_RD_ENDS:  raddr = IdxW'(n_used - 1'b1);
            ST_CHK_LAST: raddr = '0;
            ST_SEARCH:   raddr = mid[IdxW-1:0];
            ST_RD_SEG0:  raddr = n0_reg;
            ST_RD_SEG1:  raddr = n0_reg + 1'b1;
            default:     raddr = n0_reg;
        endcase
    end

    // table memories
    always_ff @(posedge aclk) begin
        if (we) begin
            xmem[s_tdata[9:0]] <= s_tdata[41:10];
            ymem[s_tdata[9:0]] <= s_tdata[73:42];
        end
        xrd_reg <= xmem[raddr];
        yrd_reg <= ymem[raddr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc && s_tuser[0] == ActQuery) state_next = ST_RD_ENDS;
            ST_RD_ENDS:     state_next = ST_CHK_LAST;
            ST_CHK_LAST:
                state_next = ($signed(key_reg) > $signed(xrd_reg)) ? ST_RD_SEG0
                                                                   : ST_CHK_FIRST;
            ST_CHK_FIRST:
                state_next = ($signed(key_reg) < $signed(xrd_reg)) ? ST_RD_SEG0
                                                                   : ST_SEARCH;
            ST_SEARCH:
                state_next = (lo_reg < hi_reg) ? ST_SEARCH_WAIT : ST_RD_SEG0;
            ST_SEARCH_WAIT: state_next = ST_SEARCH;
            ST_RD_SEG0:     state_next = ST_RD_SEG1;
            ST_RD_SEG1:     state_next = ST_SEG_WAIT;
            ST_SEG_WAIT:    state_next = ST_MULT;
            ST_MULT:        state_next = flat_reg ? ST_FINISH : ST_DIV_GO;
            ST_DIV_GO:      state_next = ST_DIV;
            ST_DIV:         if (dsts.done) state_next = ST_FINISH;
            ST_FINISH:      state_next = ST_OUT;
            ST_OUT:         if (m_tready) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // search and segment datapath
    logic              search_rd;
    logic [CntW-1:0]   mid_hold_reg;
    logic [CntW-1:0]   lo_fin;
    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        n0_next = n0_reg;
        x0_next = x0_reg;
        y0_next = y0_reg;
        x1_next = x1_reg;
        y1_next = y1_reg;
        search_rd = (state_reg == ST_SEARCH_WAIT);
        lo_fin = lo_reg;
        unique case (state_reg)
            ST_CHK_LAST: n0_next = IdxW'(n_used - CntW'(2));
            ST_CHK_FIRST: begin
                n0_next = '0;
                lo_next = '0;
                hi_next = n_used;
            end
            ST_SEARCH: begin
                if (lo_reg >= hi_reg) begin
                    if (lo_fin == '0)                       n0_next = '0;
                    else if (lo_fin - 1'b1 > n_used - CntW'(2))
                        n0_next = IdxW'(n_used - CntW'(2));
                    else                                    n0_next = IdxW'(lo_fin - 1'b1);
                end
            end
            ST_SEG_WAIT: begin
                x1_next = xrd_reg;
                y1_next = yrd_reg;
            end
            ST_RD_SEG1: begin
                x0_next = xrd_reg;
                y0_next = yrd_reg;
            end
            default: ;
        endcase
        if (search_rd) begin
            if ($signed(xrd_reg) < $signed(key_reg)) lo_next = mid_hold_reg + 1'b1;
            else                                     hi_next = mid_hold_reg;
        end
    end

    // differences, magnitudes and product
    logic signed [ValW:0] dx_w, dk_w, dy_w;
    logic [MagW-1:0]      dxm, dkm, dym;
    assign dx_w = 33'(x1_reg) - 33'(x0_reg);
    assign dk_w = 33'(key_reg) - 33'(x0_reg);
    assign dy_w = 33'(y1_reg) - 33'(y0_reg);
    assign dxm  = dx_w[ValW] ? MagW'(-dx_w) : MagW'(dx_w);
    assign dkm  = dk_w[ValW] ? MagW'(-dk_w) : MagW'(dk_w);
    assign dym  = dy_w[ValW] ? MagW'(-dy_w) : MagW'(dy_w);

    // start the divide once the product register holds this item
    assign dctl.start = (state_reg == ST_DIV_GO);

    tli_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (dctl),
        .dividend (prod_reg),
        .divisor  (dxm_reg),
        .sts      (dsts),
        .quotient (quot)
    );

    // final value and status: y0 for a flat segment, else the sum with saturation
    logic signed [QW+1:0] sum_w;
    logic                 neg_eff;
    always_comb begin
        res_next  = res_reg;
        stat_next = stat_reg;
        neg_eff   = neg_reg && (quot != '0);
        sum_w     = neg_eff ? (QW+2)'(y0_reg) - $signed({2'b00, quot})
                            : (QW+2)'(y0_reg) + $signed({2'b00, quot});
        if (state_reg == ST_FINISH) begin
            if (flat_reg) begin
                res_next  = y0_reg;
                stat_next = StatusFlat;
            end else if (sum_w > (QW+2)'(32'sh7FFFFFFF)) begin
                res_next  = 32'h7FFFFFFF;
                stat_next = StatusSat;
            end else if (sum_w < -(QW+2)'(33'sh080000000)) begin
                res_next  = 32'h80000000;
                stat_next = StatusSat;
            end else begin
                res_next  = sum_w[ValW-1:0];
                stat_next = StatusOk;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) key_reg <= s_tdata[105:74];
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        n0_reg  <= n0_next;
        x0_reg  <= x0_next;
        y0_reg  <= y0_next;
        x1_reg  <= x1_next;
        y1_reg  <= y1_next;
        res_reg <= res_next;
        stat_reg <= stat_next;
        if (state_reg == ST_SEARCH) mid_hold_reg <= mid;
        if (state_reg == ST_SEG_WAIT) flat_reg <= (xrd_reg == x0_reg);
        if (state_reg == ST_MULT) begin
            prod_reg <= ProdW'(dkm) * ProdW'(dym);
            dxm_reg  <= dxm;
            neg_reg  <= (dk_w[ValW] != dy_w[ValW]) != dx_w[ValW];
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= CntW'(2);
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) count_reg <= cfg_data;
        end
    end

`ifndef SYNTH
    a_no_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accepting while result pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[33:32] != 2'd3) else $error("bad status");
    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        dsts.busy |-> state_reg == ST_DIV) else $error("divider busy outside div");
`endif

endmodule

/* tb/table_linear_interpolator_tb.sv */
// testbench for the table linear interpolator: loads tables, runs queries, checks results
// depends on tli_pkg and table_linear_interpolator
`timescale 1ns / 1ps

module table_linear_interpolator_tb;
    import tli_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // entry_index, entry_x, entry_y, query_key, zero pad
    logic [111:0] s_tdata;
    // action
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // result_value, status, zero pad
    logic [39:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [10:0]  cfg_data;

    table_linear_interpolator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } interp_result_t;

    // predictor state
    logic [31:0]    bp_table [MaxPoints];
    logic [31:0]    val_table [MaxPoints];
    logic [10:0]    count_reg;
    interp_result_t pending_results [$];
    int             mismatches;
    bit             hold_req;
    bit             hold_busy;
    bit             ready_random;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // expected result of one query on the model tables
    function automatic interp_result_t interpolate(logic [31:0] key_bits);
        int n, n0, lo, hi, mid;
        longint key, x0, x1, y0, y1, dx, ddx, dy, r;
        logic [63:0] q;
        bit neg;
        interp_result_t res;
        n = count_reg;
        if (n < 2) n = 2;
        if (n > MaxPoints) n = MaxPoints;
        key = longint'($signed(key_bits));
        res.status = StatusOk;
        if (key > longint'($signed(bp_table[n-1]))) n0 = n - 2;
        else if (key < longint'($signed(bp_table[0]))) n0 = 0;
        else begin
            lo = 0;
            hi = n;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (longint'($signed(bp_table[mid])) < key) lo = mid + 1;
                else hi = mid;
            end
            n0 = (lo == 0) ? 0 : lo - 1;
            if (n0 > n - 2) n0 = n - 2;
        end
        x0 = longint'($signed(bp_table[n0]));
        x1 = longint'($signed(bp_table[n0+1]));
        y0 = longint'($signed(val_table[n0]));
        y1 = longint'($signed(val_table[n0+1]));
        dx = x1 - x0;
        ddx = key - x0;
        dy = y1 - y0;
        if (dx == 0) begin
            r = y0;
            res.status = StatusFlat;
        end else begin
            q = ($unsigned(ddx < 0 ? -ddx : ddx) * $unsigned(dy < 0 ? -dy : dy))
                / $unsigned(dx < 0 ? -dx : dx);
            neg = ((ddx < 0) != (dy < 0)) != (dx < 0);
            if (q == 0) neg = 0;
            if (q > 64'(1) << 34) r = neg ? -(longint'(1) << 40) : (longint'(1) << 40);
            else r = neg ? y0 - longint'(q) : y0 + longint'(q);
            if (r > 64'sd2147483647) begin
                r = 64'sd2147483647;
                res.status = StatusSat;
            end else if (r < -64'sd2147483648) begin
                r = -64'sd2147483648;
                res.status = StatusSat;
            end
        end
        res.value = r[31:0];
        return res;
    endfunction

    // send one item, updating the model on acceptance
    task automatic send_item(logic act, logic [9:0] idx, logic [31:0] ex,
                             logic [31:0] ey, logic [31:0] key);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'd0, key, ey, ex, idx};
        do @(posedge aclk); while (!s_tready);
        if (act == ActLoad) begin
            bp_table[idx]  = ex;
            val_table[idx] = ey;
        end else begin
            pending_results.push_back(interpolate(key));
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_count(logic [10:0] cnt);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cnt;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_reg = cnt;
    endtask

    // ascending table with random gaps, some duplicates
    task automatic load_table(int n, bit wide);
        longint x;
        int step;
        x = wide ? -64'sd2147483648 : longint'($signed($urandom)) / 4;
        for (int i = 0; i < n; i++) begin
            send_item(ActLoad, i[9:0], x[31:0], $urandom, $urandom);
            step = ($urandom_range(0, 9) == 0) ? 0 :
                   (wide ? int'(64'd4294967295 / n) : $urandom_range(1, 1 << 20));
            x = x + step;
            if (x > 2147483647) x = 2147483647;
        end
    endtask

    function automatic logic [31:0] pick_key(int n);
        int r, i;
        r = $urandom_range(0, 9);
        i = $urandom_range(0, n - 1);
        if (r < 4) return bp_table[i] + $urandom_range(0, 3) - 1;
        if (r < 6) return bp_table[i] + ((bp_table[i+1 < n ? i+1 : i] - bp_table[i]) >> 1);
        if (r < 7) return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {31{$urandom_range(0, 1) == 1}}};
        return $urandom;
    endfunction

    task automatic test_directed();
        send_item(ActLoad, 10'd0, 32'h0000_0000, 32'h0001_0000, 32'h0);
        send_item(ActLoad, 10'd1, 32'h0002_0000, 32'h0005_0000, 32'h0);
        send_item(ActQuery, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff, 32'h0001_0000);
        send_item(ActQuery, 10'd0, 32'h0, 32'h0, 32'h8000_0000);
        send_item(ActQuery, 10'd0, 32'h0, 32'h0, 32'h7fff_ffff);
        send_item(ActQuery, 10'd0, 32'h0, 32'h0, 32'h0000_0000);
        send_item(ActQuery, 10'd0, 32'h0, 32'h0, 32'h0002_0000);
        // zero-width segment
        send_item(ActLoad, 10'd1, 32'h0000_0000, 32'h7fff_ffff, 32'h0);
        send_item(ActQuery, 10'd0, 32'h0, 32'h0, 32'h1234_5678);
        // steep segment saturates both ways
        send_item(ActLoad, 10'd0, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_item(ActLoad, 10'd1, 32'h8000_0001, 32'h7fff_ffff, 32'h0);
        send_item(ActQuery, 10'd0, 32'h0, 32'h0, 32'h7fff_ffff);
        send_item(ActLoad, 10'd1, 32'h8000_0001, 32'h8000_0000, 32'h0);
        send_item(ActLoad, 10'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        send_item(ActQuery, 10'd0, 32'h0, 32'h0, 32'h7fff_ffff);
        // full extremes of the table
        send_item(ActLoad, 10'd0, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_item(ActLoad, 10'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
        send_item(ActQuery, 10'd0, 32'h0, 32'h0, 32'h0000_0000);
        send_item(ActQuery, 10'd0, 32'h0, 32'h0, 32'h8000_0000);
        // count below two acts as two
        write_count(11'd0);
        send_item(ActQuery, 10'd0, 32'h0, 32'h0, 32'hc000_0000);
        write_count(11'd1);
        send_item(ActQuery, 10'd0, 32'h0, 32'h0, 32'h4000_0000);
    endtask

    task automatic test_random(int cnt, int queries);
        write_count(cnt[10:0]);
        load_table(cnt > MaxPoints ? MaxPoints : cnt, 1'($urandom_range(0, 1)));
        for (int k = 0; k < queries; k++)
            send_item(ActQuery, 10'($urandom), $urandom, $urandom,
                      pick_key(cnt > MaxPoints ? MaxPoints : cnt));
    endtask

    // receiver stops for a long time while queries keep arriving
    task automatic test_backpressure();
        s_tvalid <= 1'b0;
        hold_req = 1'b1;
        wait (hold_busy);
        hold_req = 1'b0;
        for (int k = 0; k < 8; k++)
            send_item(ActQuery, 10'd0, 32'h0, 32'h0, $urandom);
        s_tvalid <= 1'b0;
        wait (!hold_busy);
    endtask

    // receiver ready pattern and long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        hold_busy = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_busy) begin
                hold_left = 1500;
                hold_busy = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
                if (hold_left == 0) hold_busy = 1'b0;
            end else if (ready_random) m_tready <= (gap_len() == 0);
            else m_tready <= 1'b1;
        end
    end

    // result checker
    initial begin
        interp_result_t exp_r;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (m_tdata[31:0] !== exp_r.value || m_tdata[33:32] !== exp_r.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected value %h status %0d, got %h status %0d",
                                     exp_r.value, exp_r.status, m_tdata[31:0], m_tdata[33:32]);
                    end
                end
            end
        end
    end

    initial begin
        mismatches   = 0;
        hold_req     = 1'b0;
        ready_random = 1'b0;
        count_reg    = 11'd2;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ActLoad;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        ready_random = 1'b1;
        test_backpressure();
        test_random(2, 60);
        test_random(3, 60);
        test_random(17, 80);
        test_random(40, 100);
        test_random(100, 40);
        test_random(5, 80);
        drain();
        if (pending_results.size() == 0 && mismatches == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/tli_pkg.sv
rtl/core/tli_divider.sv
rtl/core/table_linear_interpolator.sv
tb/table_linear_interpolator_tb.sv
